// File: rtl/tlsd_pkg.sv
// Shared types and constants for the TL string deframer.
// Used by tlsd_step and tl_string_deframer; depends on nothing else.
package tlsd_pkg;

  // Parser phase within the current string.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN3,
    PH_DATA,
    PH_PAD
  } phase_e;

  // Classification of each word on the output.
  localparam logic [1:0] KIND_PREFIX  = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_PAD     = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // Sticky error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_BADPFX  = 3'd1;
  localparam logic [2:0] ERR_TOOLONG = 3'd2;
  localparam logic [2:0] ERR_EXCEEDS = 3'd3;
  localparam logic [2:0] ERR_PADNZ   = 3'd4;
  localparam logic [2:0] ERR_SHORT   = 3'd5;

  // Prefix marker bytes.
  localparam logic [7:0] PFX_LONG = 8'd254;
  localparam logic [7:0] PFX_BAD  = 8'd255;

  // Smallest number of message bytes that lets a prefix start.
  localparam int unsigned MIN_PFX_BYTES = 4;

  // Configuration register indexes.
  localparam logic REG_MAX_LENGTH    = 1'b0;
  localparam logic REG_MESSAGE_BYTES = 1'b1;

  // Per-word flags handed from the step logic to the result register.
  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    logic       done;
  } tlsd_flags_t;

endpackage

// File: rtl/tlsd_step.sv
// Next-state and result logic of the deframer for one incoming word.
// Purely combinational; depends on tlsd_pkg.
module tlsd_step
  import tlsd_pkg::*;
#(
  parameter int LEN_BITS = 24,
  parameter int POS_BITS = 32
) (
  input  phase_e                phase_i,
  input  logic [23:0]           acc_i,
  input  logic [LEN_BITS-1:0]   left_phase_i,
  input  logic [1:0]            pos_i,
  input  logic [POS_BITS-1:0]   left_msg_i,
  input  logic [2:0]            err_i,
  input  logic [23:0]           max_len_i,
  input  logic [7:0]            byte_i,
  output phase_e                phase_o,
  output logic [23:0]           acc_o,
  output logic [LEN_BITS-1:0]   left_phase_o,
  output logic [1:0]            pos_o,
  output logic [POS_BITS-1:0]   left_msg_o,
  output logic [2:0]            err_o,
  output tlsd_flags_t           flags_o
);

  localparam int CMP_W = (POS_BITS > 24) ? POS_BITS : 24;
  localparam logic [23:0] LenMask = 24'((64'd1 << LEN_BITS) - 64'd1);

  logic [1:0]          pos_next;
  logic [POS_BITS-1:0] left_next;
  logic [23:0]         acc_len3;
  logic [1:0]          shift_k;
  logic [23:0]         len_cand;
  logic [CMP_W-1:0]    len_ext;
  logic [CMP_W-1:0]    left_ext;
  logic [1:0]          pad;
  logic                pad_short;
  logic                left_lt_min;
  logic                left_zero;
  logic                last_phase_byte;

  // Position and remaining count after this byte is consumed.
  assign pos_next  = pos_i + 2'd1;
  assign left_next = left_msg_i - POS_BITS'(1);
  assign left_zero = (left_msg_i == '0);
  assign left_lt_min = (left_msg_i < POS_BITS'(MIN_PFX_BYTES));
  assign last_phase_byte = (left_phase_i <= LEN_BITS'(1));

  // Little-endian assembly of the three-byte length.
  assign shift_k = 2'd3 - left_phase_i[1:0];
  always_comb begin
    case (shift_k)
      2'd0:    acc_len3 = acc_i | {16'd0, byte_i};
      2'd1:    acc_len3 = acc_i | {8'd0, byte_i, 8'd0};
      2'd2:    acc_len3 = acc_i | {byte_i, 16'd0};
      default: acc_len3 = acc_i;
    endcase
  end

  // The length being checked: either the short form or the assembled long form.
  assign len_cand = (phase_i == PH_IDLE) ? {16'd0, byte_i} : acc_len3;
  assign len_ext  = CMP_W'(len_cand);
  assign left_ext = CMP_W'(left_next);

  // Padding up to the next four-byte boundary after this byte.
  assign pad       = 2'd0 - pos_next;
  assign pad_short = (POS_BITS'(pad) > left_next);

  always_comb begin
    phase_o      = phase_i;
    acc_o        = acc_i;
    left_phase_o = left_phase_i;
    pos_o        = pos_i;
    left_msg_o   = left_msg_i;
    err_o        = err_i;
    flags_o.kind = KIND_IGNORED;
    flags_o.last = 1'b0;
    flags_o.done = 1'b0;

    if (err_i == ERR_NONE) begin
      case (phase_i)
        PH_IDLE: flags_o.kind = KIND_PREFIX;
        PH_LEN3: flags_o.kind = KIND_PREFIX;
        PH_DATA: flags_o.kind = KIND_DATA;
        default: flags_o.kind = KIND_PAD;
      endcase

      if ((phase_i == PH_IDLE) ? left_lt_min : left_zero) begin
        err_o = ERR_SHORT;
      end else begin
        pos_o      = pos_next;
        left_msg_o = left_next;
        case (phase_i)
          PH_IDLE, PH_LEN3: begin
            if (phase_i == PH_IDLE && byte_i == PFX_BAD) begin
              err_o = ERR_BADPFX;
            end else if (phase_i == PH_IDLE && byte_i == PFX_LONG) begin
              phase_o      = PH_LEN3;
              left_phase_o = LEN_BITS'(3);
              acc_o        = '0;
            end else if (phase_i == PH_LEN3 && !last_phase_byte) begin
              acc_o        = acc_len3;
              left_phase_o = left_phase_i - LEN_BITS'(1);
            end else begin
              // Length is now known: check it and move on.
              acc_o = len_cand;
              if (phase_i == PH_LEN3) begin
                left_phase_o = '0;
              end
              if (len_cand > max_len_i || len_cand > LenMask) begin
                err_o = ERR_TOOLONG;
              end else if (len_ext > left_ext) begin
                err_o = ERR_EXCEEDS;
              end else if (len_cand != '0) begin
                phase_o      = PH_DATA;
                left_phase_o = LEN_BITS'(len_cand);
              end else if (pad_short) begin
                err_o = ERR_SHORT;
              end else if (pad == 2'd0) begin
                flags_o.done = 1'b1;
                phase_o      = PH_IDLE;
                left_phase_o = '0;
              end else begin
                phase_o      = PH_PAD;
                left_phase_o = LEN_BITS'(pad);
              end
            end
          end
          PH_DATA: begin
            if (last_phase_byte) begin
              left_phase_o = '0;
              flags_o.last = 1'b1;
              if (pad_short) begin
                err_o = ERR_SHORT;
              end else if (pad == 2'd0) begin
                flags_o.done = 1'b1;
                phase_o      = PH_IDLE;
              end else begin
                phase_o      = PH_PAD;
                left_phase_o = LEN_BITS'(pad);
              end
            end else begin
              left_phase_o = left_phase_i - LEN_BITS'(1);
            end
          end
          default: begin
            if (byte_i != 8'd0) begin
              err_o = ERR_PADNZ;
            end else if (last_phase_byte) begin
              left_phase_o = '0;
              phase_o      = PH_IDLE;
              flags_o.done = 1'b1;
            end else begin
              left_phase_o = left_phase_i - LEN_BITS'(1);
            end
          end
        endcase
      end

      // A word that raises an error never completes a string.
      if (err_o != ERR_NONE) begin
        flags_o.done = 1'b0;
      end
    end
  end

endmodule

// File: rtl/tl_string_deframer.sv
// A result word appears in the cycle after its input word is accepted.
// Throughput: one byte per cycle while not stalled; the running state feeds
// back via one register stage and the result register decouples both channels.
// Reset (rst_ni low, asynchronous): max_length all ones, message_bytes zero,
// parser waiting for a prefix with no error and no word held on the output.
module tl_string_deframer
  import tlsd_pkg::*;
#(
  parameter int LEN_BITS = 24,
  parameter int POS_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  byte_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [23:0] string_length_o,
  output logic        last_data_o,
  output logic        string_done_o,
  output logic [2:0]  fault_code_o
);

  localparam int MB_W = (POS_BITS > 32) ? POS_BITS : 32;

  logic [23:0]         max_len_q;
  logic [31:0]         msg_bytes_q;

  phase_e              phase_q, phase_d;
  logic [23:0]         acc_q, acc_d;
  logic [LEN_BITS-1:0] left_phase_q, left_phase_d;
  logic [1:0]          pos_q, pos_d;
  logic [POS_BITS-1:0] left_msg_q, left_msg_d;
  logic [2:0]          err_q, err_d;
  tlsd_flags_t         flags_d;

  logic                out_valid_q;
  tlsd_flags_t         flags_q;
  logic [7:0]          byte_q;
  logic [23:0]         len_q;
  logic [2:0]          err_out_q;

  logic                cfg_wr;
  logic                accept;

  // Configuration access: writes complete in the access phase, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_MESSAGE_BYTES) ? msg_bytes_q : {8'd0, max_len_q};

  // Handshake: input is held off only while a result waits and is stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  tlsd_step #(
    .LEN_BITS (LEN_BITS),
    .POS_BITS (POS_BITS)
  ) u_step (
    .phase_i      (phase_q),
    .acc_i        (acc_q),
    .left_phase_i (left_phase_q),
    .pos_i        (pos_q),
    .left_msg_i   (left_msg_q),
    .err_i        (err_q),
    .max_len_i    (max_len_q),
    .byte_i       (in_byte_i),
    .phase_o      (phase_d),
    .acc_o        (acc_d),
    .left_phase_o (left_phase_d),
    .pos_o        (pos_d),
    .left_msg_o   (left_msg_d),
    .err_o        (err_d),
    .flags_o      (flags_d)
  );

  // Registers and parser state; a message_bytes write restarts the parse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= 24'hFFFFFF;
      msg_bytes_q  <= '0;
      phase_q      <= PH_IDLE;
      acc_q        <= '0;
      left_phase_q <= '0;
      pos_q        <= '0;
      left_msg_q   <= '0;
      err_q        <= ERR_NONE;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MESSAGE_BYTES) begin
        msg_bytes_q  <= pwdata;
        phase_q      <= PH_IDLE;
        acc_q        <= '0;
        left_phase_q <= '0;
        pos_q        <= '0;
        left_msg_q   <= POS_BITS'(MB_W'(pwdata));
        err_q        <= ERR_NONE;
      end else begin
        max_len_q <= pwdata[23:0];
      end
    end else if (accept) begin
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      left_phase_q <= left_phase_d;
      pos_q        <= pos_d;
      left_msg_q   <= left_msg_d;
      err_q        <= err_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q   <= flags_d;
      byte_q    <= in_byte_i;
      len_q     <= acc_d;
      err_out_q <= err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_kind_o     = flags_q.kind;
  assign out_byte_o      = byte_q;
  assign string_length_o = len_q;
  assign last_data_o     = flags_q.last;
  assign string_done_o   = flags_q.done;
  assign fault_code_o    = err_out_q;

endmodule
